/* rtl/bitmap_frame_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Shared macros for the concurrent checks of the allocator top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BFA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Sizes, command codes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int NUM_FRAMES  = 32768;
    localparam int FRAME_BYTES = 4096;
    localparam int WORD_BITS   = 32;

    localparam int NWORDS      = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int WB_W        = $clog2(WORD_BITS);
    localparam int WIDX_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int FIDX_W      = $clog2(NUM_FRAMES);
    localparam int FREE_W      = $clog2(NUM_FRAMES + 1);
    localparam int PC_W        = $clog2(WORD_BITS + 1);
    localparam int RANGE_A     = 34 - FRAME_SHIFT;
    localparam int RANGE_W     = (RANGE_A > FIDX_W + 18) ? RANGE_A : FIDX_W + 18;
    localparam int LEN_W       = 17;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RANGE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SRCH_BIT
    } state_t;

    // Number of set bits in one bitmap word.
    function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + PC_W'(w[i]);
        end
        return n;
    endfunction

    // Limit a frame bound to the end of memory.
    function automatic logic [RANGE_W-1:0] clamp_frames(input logic [RANGE_W-1:0] f);
        logic [RANGE_W-1:0] lim;
        lim = RANGE_W'(NUM_FRAMES);
        return (f > lim) ? lim : f;
    endfunction

endpackage

/* rtl/bitmap_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// Page frame allocator with one used bit per frame and a first-fit search.
// ----------------------------------------------------------------------------
// Usage: each command arrives as one transaction on the s_ channel (cmd in
// s_tuser) and gives exactly one result transaction on the m_ channel.
// After reset a clearing pass writes every bitmap word as used, one word a
// cycle (NWORDS = 1024 words); s_tready stays low during it.
// s_tready is high only while the sequencer is idle. One word is handled per
// memory access through the bitmap RAM's single registered read port.
// Free, reserve and release check their frame range, then read and write back
// each word that it touches (ST_MARK_RD, ST_MARK_WR); an empty region or a
// rejected count gives its result straight from the range check. Allocation
// reads and checks each word, scans a mixed word bit by bit, then marks the run.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and does not accept a new command until it has
// been taken.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top
    import bfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // start_addr[31:0], byte_length[63:32], frame_count[79:64]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // run_address[31:0], free_count[47:32]
    output logic        m_tuser    // alloc_ok[0]
);

    state_t               state_reg, state_next;
    logic [WIDX_W-1:0]    w_reg, w_next;
    logic [WIDX_W-1:0]    last_w_reg, last_w_next;
    logic [RANGE_W-1:0]   lo_reg, lo_next;
    logic [RANGE_W-1:0]   hi_reg, hi_next;
    logic                 set_used_reg, set_used_next;
    logic                 first_reg, first_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [FIDX_W-1:0]    start_reg, start_next;
    logic [15:0]          count_reg, count_next;
    logic [WB_W-1:0]      bit_reg, bit_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 ok_reg, ok_next;
    logic [FREE_W-1:0]    free_reg, free_next;
    logic                 done_reg, done_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [47:0]          m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] unit_word;
    logic [PC_W-1:0]      unit_changed;

    logic [31:0]          in_base;
    logic [31:0]          in_blen;
    logic [15:0]          in_cnt;
    cmd_t                 in_cmd;
    logic [32:0]          end_b;
    logic [RANGE_W-1:0]   base_dn, base_up, end_up, end_dn;
    logic [RANGE_W-1:0]   hi_m1;
    logic [FIDX_W-1:0]    st_sel;
    logic [WORD_BITS-1:0] lo_mask, hi_mask;
    logic [WB_W-1:0]      last_bit;

    // Bitmap storage.
    bfa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(NWORDS)
    ) u_bitmap (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(w_reg),
        .wdata(ram_wdata),
        .raddr(w_reg),
        .rdata(ram_rdata)
    );

    // Shared word update unit.
    bfa_word_unit u_word (
        .word_in (ram_rdata),
        .mask    (mask),
        .set_used(set_used_reg),
        .word_out(unit_word),
        .changed (unit_changed)
    );

    // Field extraction and frame bounds of the incoming command.
    always_comb begin
        in_base = s_tdata[31:0];
        in_blen = s_tdata[63:32];
        in_cnt  = s_tdata[79:64];
        in_cmd  = cmd_t'(s_tuser);
        end_b   = {1'b0, in_base} + {1'b0, in_blen};
        base_dn = RANGE_W'(in_base >> FRAME_SHIFT);
        base_up = RANGE_W'(({2'b00, in_base} + 34'(FRAME_BYTES - 1)) >> FRAME_SHIFT);
        end_up  = RANGE_W'(({1'b0, end_b} + 34'(FRAME_BYTES - 1)) >> FRAME_SHIFT);
        end_dn  = RANGE_W'(end_b >> FRAME_SHIFT);
    end

    // Bit masks of the word being marked.
    always_comb begin
        hi_m1    = hi_reg - RANGE_W'(1);
        last_bit = hi_m1[WB_W-1:0];
        lo_mask  = first_reg ? ({WORD_BITS{1'b1}} << lo_reg[WB_W-1:0])
                             : {WORD_BITS{1'b1}};
        hi_mask  = (w_reg == last_w_reg)
                 ? ({WORD_BITS{1'b1}} >> (WB_W'(WORD_BITS - 1) - last_bit))
                 : {WORD_BITS{1'b1}};
        mask     = lo_mask & hi_mask;
    end

    // State and data registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            w_reg        <= '0;
            free_reg     <= '0;
            done_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            w_reg        <= w_next;
            free_reg     <= free_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        last_w_reg   <= last_w_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        set_used_reg <= set_used_next;
        first_reg    <= first_next;
        len_reg      <= len_next;
        start_reg    <= start_next;
        count_reg    <= count_next;
        bit_reg      <= bit_next;
        word_reg     <= word_next;
        ok_reg       <= ok_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        state_next    = state_reg;
        w_next        = w_reg;
        last_w_next   = last_w_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        set_used_next = set_used_reg;
        first_next    = first_reg;
        len_next      = len_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        bit_next      = bit_reg;
        word_next     = word_reg;
        ok_next       = ok_reg;
        free_next     = free_reg;
        done_next     = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_wdata     = unit_word;
        st_sel        = start_reg;

        // Output register: drop on take, load a finished command.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (done_reg) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = ok_reg;
            m_tdata_next  = {16'(free_reg),
                             ok_reg ? 32'(64'(start_reg) << FRAME_SHIFT) : 32'd0};
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = {WORD_BITS{1'b1}};
                if (w_reg == WIDX_W'(NWORDS - 1)) begin
                    w_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    w_next = w_reg + WIDX_W'(1);
                end
            end

            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    ok_next       = 1'b0;
                    count_next    = in_cnt;
                    set_used_next = 1'b0;
                    lo_next       = '0;
                    hi_next       = '0;
                    case (in_cmd)
                        CMD_ALLOC: begin
                            w_next   = '0;
                            len_next = '0;
                            if (in_cnt != 16'd0 && 32'(in_cnt) <= 32'(NUM_FRAMES)) begin
                                state_next = ST_SRCH_RD;
                            end else begin
                                state_next = ST_RANGE;
                            end
                        end
                        CMD_FREE: begin
                            lo_next    = base_dn;
                            hi_next    = clamp_frames(base_dn + RANGE_W'(in_cnt));
                            state_next = ST_RANGE;
                        end
                        CMD_RESERVE: begin
                            set_used_next = 1'b1;
                            lo_next       = base_dn;
                            hi_next       = clamp_frames(end_up);
                            state_next    = ST_RANGE;
                        end
                        default: begin
                            lo_next    = base_up;
                            hi_next    = clamp_frames(end_dn);
                            state_next = ST_RANGE;
                        end
                    endcase
                end
            end

            ST_RANGE: begin
                if (lo_reg < hi_reg) begin
                    w_next      = WIDX_W'(lo_reg >> WB_W);
                    last_w_next = WIDX_W'(hi_m1 >> WB_W);
                    first_next  = 1'b1;
                    state_next  = ST_MARK_RD;
                end else begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_MARK_RD: begin
                state_next = ST_MARK_WR;
            end

            ST_MARK_WR: begin
                ram_we = 1'b1;
                if (set_used_reg) begin
                    free_next = (free_reg > FREE_W'(unit_changed))
                              ? free_reg - FREE_W'(unit_changed) : '0;
                end else begin
                    free_next = free_reg + FREE_W'(unit_changed);
                end
                first_next = 1'b0;
                if (w_reg == last_w_reg) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    w_next     = w_reg + WIDX_W'(1);
                    state_next = ST_MARK_RD;
                end
            end

            ST_SRCH_RD: begin
                state_next = ST_SRCH_CHK;
            end

            ST_SRCH_CHK: begin
                word_next = ram_rdata;
                bit_next  = '0;
                if (ram_rdata == {WORD_BITS{1'b1}}) begin
                    len_next = '0;
                    if (w_reg == WIDX_W'(NWORDS - 1)) begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        w_next     = w_reg + WIDX_W'(1);
                        state_next = ST_SRCH_RD;
                    end
                end else if (ram_rdata == '0) begin
                    st_sel     = (len_reg == '0) ? FIDX_W'({w_reg, {WB_W{1'b0}}}) : start_reg;
                    start_next = st_sel;
                    if (len_reg + LEN_W'(WORD_BITS) >= LEN_W'(count_reg)) begin
                        ok_next       = 1'b1;
                        set_used_next = 1'b1;
                        lo_next       = RANGE_W'(st_sel);
                        hi_next       = RANGE_W'(st_sel) + RANGE_W'(count_reg);
                        state_next    = ST_RANGE;
                    end else begin
                        len_next = len_reg + LEN_W'(WORD_BITS);
                        if (w_reg == WIDX_W'(NWORDS - 1)) begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            w_next     = w_reg + WIDX_W'(1);
                            state_next = ST_SRCH_RD;
                        end
                    end
                end else begin
                    state_next = ST_SRCH_BIT;
                end
            end

            ST_SRCH_BIT: begin
                if (word_reg[bit_reg]) begin
                    len_next = '0;
                end else begin
                    st_sel     = (len_reg == '0) ? FIDX_W'({w_reg, bit_reg}) : start_reg;
                    start_next = st_sel;
                    len_next   = len_reg + LEN_W'(1);
                end
                if (!word_reg[bit_reg] && (len_reg + LEN_W'(1) == LEN_W'(count_reg))) begin
                    ok_next       = 1'b1;
                    set_used_next = 1'b1;
                    lo_next       = RANGE_W'(st_sel);
                    hi_next       = RANGE_W'(st_sel) + RANGE_W'(count_reg);
                    state_next    = ST_RANGE;
                end else if (bit_reg != WB_W'(WORD_BITS - 1)) begin
                    bit_next = bit_reg + WB_W'(1);
                end else if (w_reg == WIDX_W'(NWORDS - 1)) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    w_next     = w_reg + WIDX_W'(1);
                    state_next = ST_SRCH_RD;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A new command is taken only when idle and no result is pending.
    assign s_tready = (state_reg == ST_IDLE) && !done_reg && !m_tvalid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "bitmap_frame_allocator_top_assert.svh"

    `BFA_ASSERT_IMPL(a_free_bound, 1'b1, free_reg <= FREE_W'(NUM_FRAMES), "free count too large")
    `BFA_ASSERT_IMPL(a_fail_addr, m_tvalid && !m_tuser, m_tdata[31:0] == 32'd0, "bad fail address")
    `BFA_ASSERT_NEXT(a_one_cmd, s_tvalid && s_tready, !s_tready, "command taken while busy")

endmodule

/* rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bfa_word_unit.sv */
// ----------------------------------------------------------------------------
// Bitmap word update unit
// Sets or clears the masked bits of one word and counts the bits that change.
// ----------------------------------------------------------------------------
module bfa_word_unit
    import bfa_pkg::*;
(
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [WORD_BITS-1:0] mask,
    input  logic                 set_used,
    output logic [WORD_BITS-1:0] word_out,
    output logic [PC_W-1:0]      changed
);

    logic [WORD_BITS-1:0] flip;

    // Only bits that really change state are counted.
    always_comb begin
        flip     = set_used ? (mask & ~word_in) : (mask & word_in);
        word_out = word_in ^ flip;
        changed  = popcount(flip);
    end

endmodule
